@@ sv/hfr_pkg.sv @@
// ----------------------------------------------------------------------------
// hfr_pkg: shared types and functions of the hex frame receiver
// Holds the phase encoding, the receiver state and result records, the
// framing character codes, the hex digit decode and the byte-wide CRC update.
// ----------------------------------------------------------------------------
`default_nettype none

package hfr_pkg;

    // Framing control characters.
    localparam logic [7:0] CHAR_SOH = 8'h01;
    localparam logic [7:0] CHAR_STX = 8'h02;
    localparam logic [7:0] CHAR_ETX = 8'h03;
    localparam logic [7:0] CHAR_EOT = 8'h04;

    // Reflected CRC-16-CCITT polynomial.
    localparam logic [15:0] CRC_POLY = 16'h8408;

    // Highest CRC digit offset that still fits the 16-bit value.
    localparam logic [4:0] CRC_LAST_SHIFT = 5'd12;

    // Receiver phase, reported as the status of each result beat.
    typedef enum logic [2:0] {
        PH_IDLE   = 3'd0,
        PH_HEAD   = 3'd1,
        PH_DATA   = 3'd2,
        PH_CRC    = 3'd3,
        PH_OK     = 3'd4,
        PH_CRCERR = 3'd5,
        PH_OVF    = 3'd6,
        PH_ILL    = 3'd7
    } phase_t;

    // Receiver state carried from one character to the next.
    typedef struct packed {
        phase_t      phase;
        logic [15:0] crc_running;
        logic [15:0] crc_received;
        logic [4:0]  digit_count;
        logic [3:0]  high_nibble;
        logic [12:0] byte_count;
    } rx_state_t;

    // One result beat.
    typedef struct packed {
        phase_t      status;
        logic        byte_valid;
        logic [7:0]  data_byte;
        logic [11:0] byte_index;
        logic [12:0] frame_length;
    } rx_result_t;

    function automatic logic is_hex(input logic [7:0] c);
        logic r;
        r = (c >= 8'h30 && c <= 8'h39) || (c >= 8'h41 && c <= 8'h46) ||
            (c >= 8'h61 && c <= 8'h66);
        return r;
    endfunction

    // Only the low nibble of the offset subtraction is kept, which is the
    // digit value for every legal hex character.
    function automatic logic [3:0] hex_value(input logic [7:0] c);
        logic [7:0] d;
        if (c <= 8'h39) begin
            d = c - 8'h30;
        end else if (c <= 8'h46) begin
            d = c - 8'h37;
        end else begin
            d = c - 8'h57;
        end
        return d[3:0];
    endfunction

    function automatic logic [15:0] crc_update(input logic [15:0] crc_in,
                                               input logic [7:0]  c);
        logic [15:0] crc;
        crc = crc_in ^ {8'h00, c};
        for (int i = 0; i < 8; i++) begin
            if (crc[0]) begin
                crc = (crc >> 1) ^ CRC_POLY;
            end else begin
                crc = crc >> 1;
            end
        end
        return crc;
    endfunction

endpackage

`default_nettype wire

@@ sv/hex_frame_receiver_crc_top.sv @@
// ----------------------------------------------------------------------------
// hex_frame_receiver_crc_top: ASCII hex frame receiver with CRC-16 check
// Decodes SOH/STX/hex data/ETX/hex CRC/EOT frames, one character a beat.
// ----------------------------------------------------------------------------
// Usage:
//   The s_ channel carries one received character per beat (s_rx_char).
//   Every accepted character produces exactly one result beat on the m_
//   channel: the phase after that character (m_status), a decoded data
//   byte with its index when the character completed a hex pair, and the
//   count of data bytes stored so far in the frame.
//   The CRC start value is written through cfg_wr_en/cfg_wr_data while the
//   block is idle; it is loaded into the running CRC at each SOH.
// Result timing and throughput:
//   A result is visible in the cycle after its character is accepted. The
//   whole decode and the byte-wide CRC update sit between the state
//   registers and the result register, so one character is taken every
//   cycle unless the result side stalls.
// Reset and stall:
//   Synchronous active-low reset returns the phase to idle, clears the
//   counters and CRC registers, and sets the CRC start value to 0xFFFF.
//   When the receiver holds m_ready low the result register keeps its
//   beat and s_ready drops until that beat is taken.
// ----------------------------------------------------------------------------
`default_nettype none

module hex_frame_receiver_crc_top #(
    parameter int BUF_SIZE = 64
) (
    input  wire  logic        aclk,
    input  wire  logic        aresetn,

    input  wire  logic        cfg_wr_en,
    input  wire  logic [15:0] cfg_wr_data,

    input  wire  logic        s_valid,
    output logic              s_ready,
    input  wire  logic [7:0]  s_rx_char,

    output logic              m_valid,
    input  wire  logic        m_ready,
    output logic [2:0]        m_status,
    output logic              m_byte_valid,
    output logic [7:0]        m_data_byte,
    output logic [11:0]       m_byte_index,
    output logic [12:0]       m_frame_length
);

    hfr_pkg::rx_state_t  state_reg;
    hfr_pkg::rx_state_t  state_next;
    hfr_pkg::rx_result_t result_reg;
    hfr_pkg::rx_result_t result_next;
    logic [15:0]         crc_start_reg;
    logic                m_valid_reg;
    logic                accept;

    // The result register can take a new beat whenever it is empty or its
    // current beat leaves in this same cycle.
    assign s_ready = !m_valid_reg || m_ready;
    assign accept  = s_valid && s_ready;

    hfr_step #(
        .BUF_SIZE (BUF_SIZE)
    ) u_step (
        .cur_state (state_reg),
        .rx_char   (s_rx_char),
        .crc_start (crc_start_reg),
        .nxt_state (state_next),
        .result    (result_next)
    );

    // Configuration register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            crc_start_reg <= 16'hFFFF;
        end else if (cfg_wr_en) begin
            crc_start_reg <= cfg_wr_data;
        end
    end

    // Receiver state advances on every accepted character.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg.phase        <= hfr_pkg::PH_IDLE;
            state_reg.crc_running  <= 16'h0000;
            state_reg.crc_received <= 16'h0000;
            state_reg.digit_count  <= 5'd0;
            state_reg.high_nibble  <= 4'h0;
            state_reg.byte_count   <= 13'd0;
        end else if (accept) begin
            state_reg <= state_next;
        end
    end

    // Output valid flag.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (accept) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    // Result payload; it needs no reset since m_valid gates it.
    always_ff @(posedge aclk) begin
        if (accept) begin
            result_reg <= result_next;
        end
    end

    assign m_valid        = m_valid_reg;
    assign m_status       = result_reg.status;
    assign m_byte_valid   = result_reg.byte_valid;
    assign m_data_byte    = result_reg.data_byte;
    assign m_byte_index   = result_reg.byte_index;
    assign m_frame_length = result_reg.frame_length;

`ifndef SYNTHESIS
    // A decoded byte only ever appears while a frame is in its data phase.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_byte_valid |-> m_status == hfr_pkg::PH_DATA)
        else $error("byte emitted outside data phase");

    // Without a decoded byte the byte fields read as zero.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_byte_valid |-> m_data_byte == 8'h00 && m_byte_index == 12'h000)
        else $error("byte fields not cleared");

    // The stored count is one past the index of the byte just emitted.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_byte_valid |-> m_frame_length == {1'b0, m_byte_index} + 13'd1)
        else $error("frame length does not follow byte index");

    // The stored count never exceeds the buffer size.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> m_frame_length <= 13'(BUF_SIZE))
        else $error("frame length beyond buffer size");

    // A stalled result blocks the input side.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |-> !s_ready)
        else $error("input accepted while result stalled");
`endif

endmodule

`default_nettype wire

@@ sv/hfr_step.sv @@
// ----------------------------------------------------------------------------
// hfr_step: per-character frame decode
// Combinational next-state and result logic for one received character.
// ----------------------------------------------------------------------------
`default_nettype none

module hfr_step #(
    parameter int BUF_SIZE = 64
) (
    input  wire  hfr_pkg::rx_state_t  cur_state,
    input  wire  logic [7:0]          rx_char,
    input  wire  logic [15:0]         crc_start,
    output hfr_pkg::rx_state_t        nxt_state,
    output hfr_pkg::rx_result_t       result
);

    localparam logic [12:0] BufLimit = 13'(BUF_SIZE);

    logic [3:0]  digit_val;
    logic [3:0]  crc_shift;
    logic [15:0] crc_digit;

    assign digit_val = hfr_pkg::hex_value(rx_char);
    assign crc_shift = 4'(hfr_pkg::CRC_LAST_SHIFT - cur_state.digit_count);
    assign crc_digit = {12'h000, digit_val} << crc_shift;

    always_comb begin
        nxt_state          = cur_state;
        result.byte_valid  = 1'b0;
        result.data_byte   = 8'h00;
        result.byte_index  = 12'h000;

        // A good frame is shown for one beat only.
        if (cur_state.phase == hfr_pkg::PH_OK) begin
            nxt_state.phase = hfr_pkg::PH_IDLE;
        end

        if (rx_char == hfr_pkg::CHAR_SOH) begin
            nxt_state.crc_running = crc_start;
            nxt_state.phase       = hfr_pkg::PH_HEAD;
            nxt_state.byte_count  = 13'd0;
        end else if (rx_char == hfr_pkg::CHAR_STX) begin
            if (cur_state.phase == hfr_pkg::PH_HEAD) begin
                nxt_state.digit_count = 5'd0;
                nxt_state.phase       = hfr_pkg::PH_DATA;
            end else begin
                nxt_state.phase = hfr_pkg::PH_IDLE;
            end
        end else if (rx_char == hfr_pkg::CHAR_ETX) begin
            if (cur_state.phase == hfr_pkg::PH_DATA) begin
                nxt_state.digit_count  = 5'd0;
                nxt_state.crc_received = 16'h0000;
                nxt_state.phase        = hfr_pkg::PH_CRC;
            end else begin
                nxt_state.phase = hfr_pkg::PH_IDLE;
            end
        end else if (rx_char == hfr_pkg::CHAR_EOT) begin
            if (cur_state.phase == hfr_pkg::PH_CRC) begin
                nxt_state.phase = (cur_state.crc_running == cur_state.crc_received) ?
                                  hfr_pkg::PH_OK : hfr_pkg::PH_CRCERR;
            end else begin
                nxt_state.phase = hfr_pkg::PH_IDLE;
            end
        end else if (hfr_pkg::is_hex(rx_char)) begin
            if (cur_state.phase == hfr_pkg::PH_DATA) begin
                nxt_state.crc_running = hfr_pkg::crc_update(cur_state.crc_running, rx_char);
                nxt_state.digit_count = cur_state.digit_count + 5'd1;
                if (cur_state.digit_count[0]) begin
                    if (cur_state.byte_count < BufLimit) begin
                        result.byte_valid    = 1'b1;
                        result.data_byte     = {cur_state.high_nibble, digit_val};
                        result.byte_index    = cur_state.byte_count[11:0];
                        nxt_state.byte_count = cur_state.byte_count + 13'd1;
                    end else begin
                        nxt_state.phase = hfr_pkg::PH_OVF;
                    end
                end else begin
                    nxt_state.high_nibble = digit_val;
                end
            end else if (cur_state.phase == hfr_pkg::PH_CRC) begin
                if (cur_state.digit_count <= hfr_pkg::CRC_LAST_SHIFT) begin
                    nxt_state.crc_received = cur_state.crc_received + crc_digit;
                    nxt_state.digit_count  = cur_state.digit_count + 5'd4;
                end else begin
                    nxt_state.phase = hfr_pkg::PH_ILL;
                end
            end else begin
                nxt_state.phase = hfr_pkg::PH_IDLE;
            end
        end

        result.status       = nxt_state.phase;
        result.frame_length = nxt_state.byte_count;
    end

endmodule

`default_nettype wire

@@ sim/tb_top.sv @@
// ----------------------------------------------------------------------------
// tb_top: self-checking bench for the hex frame receiver with CRC-16 check
// Characters are sent one beat at a time through a queue-fed driver. Each
// accepted character is run through a behavioral decoder kept in this file,
// and every result beat is checked field by field against the decoded
// expectations, in order. Both channels stall at random. The CRC start
// register is rewritten between phases while the receiver is quiet.
// ----------------------------------------------------------------------------
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int BUF_DEPTH       = 64;
    localparam int IDLE_PCT        = 31;
    localparam int ITEMS_PER_PHASE = 120;
    localparam int NUM_PHASES      = 5;
    localparam int STALL_LIMIT     = 4000;
    localparam int TAIL_CYCLES     = 10;
    localparam int MAX_PRINTED     = 100;

    // Shapes of generated frames.
    typedef enum int {
        FR_GOOD,
        FR_BADCRC,
        FR_SHORT,
        FR_EXTRA,
        FR_BROKEN
    } frame_kind_t;

    logic        aclk        = 1'b0;
    logic        aresetn     = 1'b0;
    logic        cfg_wr_en   = 1'b0;
    logic [15:0] cfg_wr_data = '0;
    logic        s_valid     = 1'b0;
    logic        s_ready;
    logic [7:0]  s_rx_char   = '0;
    logic        m_valid;
    logic        m_ready     = 1'b0;
    logic [2:0]  m_status;
    logic        m_byte_valid;
    logic [7:0]  m_data_byte;
    logic [11:0] m_byte_index;
    logic [12:0] m_frame_length;

    // Decoder state, mirrored from the receiver's behavior.
    hfr_pkg::phase_t rx_phase   = hfr_pkg::PH_IDLE;
    logic [15:0]     crc_seed   = 16'hFFFF;
    logic [15:0]     crc_acc    = '0;
    logic [15:0]     crc_rcvd   = '0;
    logic [4:0]      digit_cnt  = '0;
    logic [3:0]      hi_nib     = '0;
    logic [12:0]     stored_cnt = '0;

    // Characters waiting to be sent, and decoded results waiting to arrive.
    logic [7:0]          tx_chars[$];
    hfr_pkg::rx_result_t decoded_q[$];
    hfr_pkg::rx_result_t want_beat;

    bit beat_sent    = 1'b0;
    bit burst_mode   = 1'b0;
    bit src_hold     = 1'b0;
    int err_cnt      = 0;
    int result_beats = 0;
    int random_items = 0;
    int stall_cycles = 0;

    hex_frame_receiver_crc_top #(
        .BUF_SIZE(BUF_DEPTH)
    ) dut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_wr_data   (cfg_wr_data),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_rx_char     (s_rx_char),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_status      (m_status),
        .m_byte_valid  (m_byte_valid),
        .m_data_byte   (m_data_byte),
        .m_byte_index  (m_byte_index),
        .m_frame_length(m_frame_length)
    );

    initial begin
        forever #4 aclk = ~aclk;
    end

    // Bit 4 of the result flags a legal hex digit, the low nibble is its value.
    function automatic logic [4:0] hex_nibble(input logic [7:0] ch);
        if (ch >= "0" && ch <= "9") begin
            return {1'b1, ch[3:0]};
        end
        if ((ch >= "A" && ch <= "F") || (ch >= "a" && ch <= "f")) begin
            return {1'b1, ch[3:0] + 4'd9};
        end
        return 5'd0;
    endfunction

    function automatic logic [7:0] hex_char(input logic [3:0] v, input bit lower);
        if (v < 4'd10) begin
            return 8'h30 + v;
        end
        return (lower ? 8'h61 : 8'h41) + v - 8'd10;
    endfunction

    // One byte through the reflected CRC-16-CCITT register, LSB first.
    function automatic logic [15:0] crc_step(input logic [15:0] acc, input logic [7:0] ch);
        logic [15:0] r;
        r = acc ^ {8'h00, ch};
        repeat (8) begin
            if (r[0]) begin
                r = {1'b0, r[15:1]} ^ hfr_pkg::CRC_POLY;
            end else begin
                r = {1'b0, r[15:1]};
            end
        end
        return r;
    endfunction

    // A character that is neither a control code nor a hex digit.
    function automatic logic [7:0] filler_char();
        logic [7:0] c;
        logic [4:0] hx;
        bit         ok;
        ok = 1'b0;
        c  = '0;
        while (!ok) begin
            c  = 8'($urandom_range(255));
            hx = hex_nibble(c);
            ok = !hx[4] && !(c >= hfr_pkg::CHAR_SOH && c <= hfr_pkg::CHAR_EOT);
        end
        return c;
    endfunction

    // Advances the decoder by one character and returns the result it yields.
    function automatic hfr_pkg::rx_result_t decode_char(input logic [7:0] ch);
        hfr_pkg::rx_result_t r;
        logic [4:0]          hx;
        logic [15:0]         weighted;
        r  = '0;
        hx = hex_nibble(ch);
        // A finished good frame falls back to idle on whatever comes next.
        if (rx_phase == hfr_pkg::PH_OK) begin
            rx_phase = hfr_pkg::PH_IDLE;
        end
        if (ch == hfr_pkg::CHAR_SOH) begin
            crc_acc    = crc_seed;
            rx_phase   = hfr_pkg::PH_HEAD;
            stored_cnt = '0;
        end else if (ch == hfr_pkg::CHAR_STX) begin
            if (rx_phase == hfr_pkg::PH_HEAD) begin
                digit_cnt = '0;
                rx_phase  = hfr_pkg::PH_DATA;
            end else begin
                rx_phase = hfr_pkg::PH_IDLE;
            end
        end else if (ch == hfr_pkg::CHAR_ETX) begin
            if (rx_phase == hfr_pkg::PH_DATA) begin
                digit_cnt = '0;
                crc_rcvd  = '0;
                rx_phase  = hfr_pkg::PH_CRC;
            end else begin
                rx_phase = hfr_pkg::PH_IDLE;
            end
        end else if (ch == hfr_pkg::CHAR_EOT) begin
            if (rx_phase != hfr_pkg::PH_CRC) begin
                rx_phase = hfr_pkg::PH_IDLE;
            end else if (crc_acc == crc_rcvd) begin
                rx_phase = hfr_pkg::PH_OK;
            end else begin
                rx_phase = hfr_pkg::PH_CRCERR;
            end
        end else if (hx[4]) begin
            if (rx_phase == hfr_pkg::PH_DATA) begin
                // The CRC covers the ASCII code, even for the digit that overflows.
                crc_acc = crc_step(crc_acc, ch);
                if (digit_cnt[0]) begin
                    if (stored_cnt < BUF_DEPTH) begin
                        r.byte_valid = 1'b1;
                        r.data_byte  = {hi_nib, hx[3:0]};
                        r.byte_index = stored_cnt[11:0];
                        stored_cnt   = stored_cnt + 1'b1;
                    end else begin
                        rx_phase = hfr_pkg::PH_OVF;
                    end
                end else begin
                    hi_nib = hx[3:0];
                end
                digit_cnt = digit_cnt + 1'b1;
            end else if (rx_phase == hfr_pkg::PH_CRC) begin
                // Digits fill from the top nibble down; a fifth one is illegal.
                if (digit_cnt <= hfr_pkg::CRC_LAST_SHIFT) begin
                    weighted  = {12'h000, hx[3:0]} << (hfr_pkg::CRC_LAST_SHIFT - digit_cnt);
                    crc_rcvd  = crc_rcvd + weighted;
                    digit_cnt = digit_cnt + 5'd4;
                end else begin
                    rx_phase = hfr_pkg::PH_ILL;
                end
            end else begin
                rx_phase = hfr_pkg::PH_IDLE;
            end
        end
        r.status       = rx_phase;
        r.frame_length = stored_cnt;
        return r;
    endfunction

    task automatic report_mismatch(input string what, input int got, input int want);
        if (err_cnt < MAX_PRINTED) begin
            $display("[%0t] result %0d: %s mismatch, got 0x%0h, expected 0x%0h",
                     $time, result_beats, what, got, want);
        end
        err_cnt++;
    endtask

    task automatic send_char(input logic [7:0] c, input bit counted);
        tx_chars.push_back(c);
        if (counted) begin
            random_items++;
        end
    endtask

    // Queues one frame of the given shape. A negative nbytes picks a small
    // random payload length.
    task automatic queue_frame(input frame_kind_t kind, input int nbytes);
        logic [7:0]  fr[$];
        logic [15:0] crc;
        logic [7:0]  data;
        logic [7:0]  ch;
        logic [7:0]  intruder;
        logic [3:0]  nib;
        int          ndigits;
        int          cut;
        int          i;
        crc      = crc_seed;
        data     = '0;
        intruder = '0;
        cut      = -1;
        if (nbytes < 0) begin
            nbytes = $urandom_range(6, 0);
        end
        fr.push_back(hfr_pkg::CHAR_SOH);
        fr.push_back(hfr_pkg::CHAR_STX);
        for (i = 0; i < 2 * nbytes; i++) begin
            if (i % 2 == 0) begin
                data = 8'($urandom);
            end
            ch = hex_char((i % 2 == 1) ? data[3:0] : data[7:4], 1'($urandom_range(1)));
            fr.push_back(ch);
            crc = crc_step(crc, ch);
        end
        fr.push_back(hfr_pkg::CHAR_ETX);
        case (kind)
            FR_SHORT: ndigits = $urandom_range(3, 0);
            FR_EXTRA: ndigits = 5;
            default:  ndigits = 4;
        endcase
        if (kind == FR_BADCRC) begin
            crc = crc ^ (16'h0001 << $urandom_range(15));
        end
        for (i = 0; i < ndigits; i++) begin
            if (i < 4) begin
                nib = crc[15 - 4 * i -: 4];
            end else begin
                nib = 4'($urandom);
            end
            fr.push_back(hex_char(nib, 1'($urandom_range(1))));
        end
        fr.push_back(hfr_pkg::CHAR_EOT);
        // A broken frame gets a control code or a digit where it does not belong.
        if (kind == FR_BROKEN) begin
            cut = $urandom_range(fr.size() - 1, 1);
            nib = 4'($urandom);
            case ($urandom_range(4))
                0:       intruder = hfr_pkg::CHAR_SOH;
                1:       intruder = hfr_pkg::CHAR_STX;
                2:       intruder = hfr_pkg::CHAR_ETX;
                3:       intruder = hfr_pkg::CHAR_EOT;
                default: intruder = hex_char(nib, 1'b0);
            endcase
        end
        foreach (fr[k]) begin
            if (k == cut) begin
                send_char(intruder, 1'b1);
            end
            // Ignored characters sprinkled in; they do not count as stimulus.
            if ($urandom_range(99) < 8) begin
                send_char(filler_char(), 1'b0);
            end
            send_char(fr[k], 1'b1);
        end
    endtask

    // Returns once nothing is in flight. With src_hold set, characters still
    // queued are left alone.
    task automatic settle();
        while (s_valid || decoded_q.size() != 0 || (!src_hold && tx_chars.size() != 0)) begin
            @(posedge aclk);
        end
    endtask

    task automatic load_crc_start(input logic [15:0] value);
        @(negedge aclk);
        cfg_wr_en   = 1'b1;
        cfg_wr_data = value;
        crc_seed    = value;
        @(negedge aclk);
        cfg_wr_en = 1'b0;
    endtask

    // Driver: a new character goes out on the falling edge once the last one
    // was taken. The result side's ready is drawn here as well.
    always @(negedge aclk) begin
        if (!s_valid || beat_sent) begin
            if (aresetn && tx_chars.size() != 0 && !src_hold &&
                (burst_mode || $urandom_range(99) >= IDLE_PCT)) begin
                s_valid   <= 1'b1;
                s_rx_char <= tx_chars.pop_front();
            end else begin
                s_valid <= 1'b0;
            end
        end
        beat_sent = 1'b0;
        m_ready <= burst_mode || ($urandom_range(99) >= IDLE_PCT);
    end

    // Monitor: checks result beats, decodes accepted characters and keeps the
    // watchdog. Results are checked before the new expectation is queued.
    always @(posedge aclk) begin
        if (aresetn) begin
            if (m_valid && m_ready) begin
                result_beats++;
                if (decoded_q.size() == 0) begin
                    report_mismatch("unexpected beat, status", m_status, 0);
                end else begin
                    want_beat = decoded_q.pop_front();
                    if (m_status != want_beat.status) begin
                        report_mismatch("status", m_status, want_beat.status);
                    end
                    if (m_byte_valid != want_beat.byte_valid) begin
                        report_mismatch("byte_valid", m_byte_valid, want_beat.byte_valid);
                    end
                    if (m_data_byte != want_beat.data_byte) begin
                        report_mismatch("data_byte", m_data_byte, want_beat.data_byte);
                    end
                    if (m_byte_index != want_beat.byte_index) begin
                        report_mismatch("byte_index", m_byte_index, want_beat.byte_index);
                    end
                    if (m_frame_length != want_beat.frame_length) begin
                        report_mismatch("frame_length", m_frame_length,
                                        want_beat.frame_length);
                    end
                end
            end
            if (s_valid && s_ready) begin
                decoded_q.push_back(decode_char(s_rx_char));
                beat_sent = 1'b1;
            end
            if ((s_valid && s_ready) || (m_valid && m_ready)) begin
                stall_cycles = 0;
            end else begin
                stall_cycles++;
                if (stall_cycles >= STALL_LIMIT) begin
                    $display("[%0t] watchdog: no beat moved for %0d cycles",
                             $time, STALL_LIMIT);
                    $display("DONE: errors detected");
                    $finish;
                end
            end
        end
    end

    initial begin : stimulus
        logic [15:0] crc;
        logic [31:0] word;
        frame_kind_t kind;
        int          p;
        int          r;
        int          i;
        repeat (2) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;

        // Code extremes and a stray digit while idle, then each control
        // character arriving out of order.
        send_char(8'h00, 1'b1);
        send_char(8'hFF, 1'b1);
        send_char(8'h80, 1'b1);
        send_char("A", 1'b1);
        send_char(hfr_pkg::CHAR_STX, 1'b1);
        send_char(hfr_pkg::CHAR_ETX, 1'b1);
        send_char(hfr_pkg::CHAR_EOT, 1'b1);
        // A good frame carrying 0xFF and 0x00 in mixed case, then a character
        // that takes the receiver from frame ok back to idle.
        word = "Ff00";
        crc  = crc_seed;
        send_char(hfr_pkg::CHAR_SOH, 1'b1);
        send_char(hfr_pkg::CHAR_STX, 1'b1);
        for (i = 3; i >= 0; i--) begin
            send_char(word[8 * i +: 8], 1'b1);
            crc = crc_step(crc, word[8 * i +: 8]);
        end
        send_char(hfr_pkg::CHAR_ETX, 1'b1);
        for (i = 0; i < 4; i++) begin
            send_char(hex_char(crc[15 - 4 * i -: 4], 1'b0), 1'b1);
        end
        send_char(hfr_pkg::CHAR_EOT, 1'b1);
        send_char("z", 1'b1);
        // An empty frame that runs into a fifth CRC digit.
        send_char(hfr_pkg::CHAR_SOH, 1'b1);
        send_char(hfr_pkg::CHAR_STX, 1'b1);
        send_char(hfr_pkg::CHAR_ETX, 1'b1);
        repeat (5) send_char("0", 1'b1);

        random_items = 0;
        for (p = 0; p < NUM_PHASES; p++) begin
            settle();
            case (p)
                0:       load_crc_start(16'h0000);
                1:       load_crc_start(16'hFFFF);
                3:       load_crc_start(16'h8000);
                default: load_crc_start(16'($urandom));
            endcase
            // One phase runs with neither side idling.
            burst_mode = (p == 2);
            // Long frames: one that overflows the buffer, one that fills it exactly.
            if (p == 1) begin
                queue_frame(FR_GOOD, BUF_DEPTH + 1);
            end else if (p == 3) begin
                queue_frame(FR_GOOD, BUF_DEPTH);
            end
            while (random_items < (p + 1) * ITEMS_PER_PHASE) begin
                if ($urandom_range(99) < 15) begin
                    send_char(8'($urandom_range(255)), 1'b1);
                end
                r = $urandom_range(99);
                if (r < 45) begin
                    kind = FR_GOOD;
                end else if (r < 60) begin
                    kind = FR_BADCRC;
                end else if (r < 70) begin
                    kind = FR_SHORT;
                end else if (r < 80) begin
                    kind = FR_EXTRA;
                end else begin
                    kind = FR_BROKEN;
                end
                queue_frame(kind, -1);
            end
            // Midway through one phase the sender stops until every result is in.
            if (p == 3) begin
                while (tx_chars.size() > 40) begin
                    @(posedge aclk);
                end
                src_hold = 1'b1;
                settle();
                repeat ($urandom_range(20, 5)) @(posedge aclk);
                src_hold = 1'b0;
            end
        end

        settle();
        burst_mode = 1'b0;
        repeat (TAIL_CYCLES) @(posedge aclk);
        if (decoded_q.size() != 0) begin
            report_mismatch("results never delivered, count", decoded_q.size(), 0);
        end
        if (err_cnt == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule
